FILE: sv/tgv_pkg.sv
// tgv_pkg: shared types, constants and helpers of the torus grid vertex generator.
// No dependencies; tgv_sincos, tgv_combine and the core use it by scoped names.
`timescale 1ns / 1ps

package tgv_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int MAX_SIDES      = 256;
	localparam int RING_MIN       = 3;
	localparam int TUBE_MIN       = 2;

	localparam logic [8:0]  RING_RESET  = 9'd3;
	localparam logic [8:0]  TUBE_RESET  = 9'd2;
	localparam logic [14:0] MAJOR_RESET = 15'd11469;
	localparam logic [14:0] MINOR_RESET = 15'd4915;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	// Taylor coefficients in Q1.30, lowest order first
	localparam logic [30:0] SIN_COEF [5] = '{31'd1686629713, 31'd693598669, 31'd85569306,
		31'd5026994, 31'd172272};
	localparam logic [30:0] COS_COEF [5] = '{31'd1324675878, 31'd272375557, 31'd22401990,
		31'd987048, 31'd27061};

	typedef enum logic [1:0] {
		REG_RING  = 2'd0,
		REG_TUBE  = 2'd1,
		REG_MAJOR = 2'd2,
		REG_MINOR = 2'd3
	} reg_addr_t;

	// quarter-wave result as sign and magnitude (magnitude <= 1.0 in Q30)
	typedef struct packed {
		logic [30:0] sin_mag;
		logic        sin_neg;
		logic [30:0] cos_mag;
		logic        cos_neg;
	} sincos_t;

	// data that rides alongside the angle pipeline
	typedef struct packed {
		logic        err;
		logic [15:0] tex_u;
		logic [15:0] tex_v;
		logic [15:0] idx_cur;
		logic [15:0] idx_nr;
		logic [15:0] idx_dg;
		logic [15:0] idx_nt;
	} side_t;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] pos_z;
		logic [15:0] tex_u;
		logic [15:0] tex_v;
		logic [15:0] idx_cur;
		logic [15:0] idx_nr;
		logic [15:0] idx_dg;
		logic [15:0] idx_nt;
		logic        err;
	} result_t;

	// one Horner step: c - (p*y >> 30), floored at zero
	function automatic logic [30:0] horner_step(input logic [30:0] p, input logic [29:0] y,
		input logic [30:0] c);
		logic [60:0] prod;
		logic [30:0] t;
		prod = 61'(p) * 61'(y);
		t = prod[60:30];
		return (t >= c) ? 31'd0 : 31'(c - t);
	endfunction

endpackage

FILE: sv/tgv_div.sv
// tgv_div: pipelined restoring divider, floor(dividend * 2^QBITS / divisor),
// two quotient bits per stage. Depends on nothing but the caller's stage enables.
`timescale 1ns / 1ps

module tgv_div #(
	parameter int QBITS = 16,
	localparam int STAGES = (QBITS + 1) / 2
) (
	input  logic              clk,
	input  logic [STAGES-1:0] en,
	input  logic [7:0]        dividend,
	input  logic [8:0]        divisor,
	output logic [QBITS-1:0]  quotient
);

	logic [8:0]       rem_sd [STAGES];
	logic [8:0]       dvs_sd [STAGES];
	logic [QBITS-1:0] quo_sd [STAGES];

	for (genvar d = 0; d < STAGES; d++) begin : g_stage
		logic [8:0]       rem_in;
		logic [8:0]       dvs_in;
		logic [QBITS-1:0] quo_in;
		logic [8:0]       rem_nx;
		logic [QBITS-1:0] quo_nx;

		if (d == 0) begin : g_first
			assign rem_in = {1'b0, dividend};
			assign dvs_in = divisor;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_sd[d-1];
			assign dvs_in = dvs_sd[d-1];
			assign quo_in = quo_sd[d-1];
		end

		always_comb begin
			logic [9:0] dbl;
			dbl = '0;
			rem_nx = rem_in;
			quo_nx = quo_in;
			for (int s = 0; s < 2; s++) begin
				if (2 * d + s < QBITS) begin
					dbl = {rem_nx, 1'b0};
					if (dbl >= {1'b0, dvs_in}) begin
						dbl = dbl - {1'b0, dvs_in};
						quo_nx = {quo_nx[QBITS-2:0], 1'b1};
					end else begin
						quo_nx = {quo_nx[QBITS-2:0], 1'b0};
					end
					rem_nx = dbl[8:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[d]) begin
				rem_sd[d] <= rem_nx;
				dvs_sd[d] <= dvs_in;
				quo_sd[d] <= quo_nx;
			end
		end
	end

	assign quotient = quo_sd[STAGES-1];

endmodule

FILE: sv/tgv_sincos.sv
// tgv_sincos: six-stage fixed-point sine/cosine of a phase in turns.
// Uses tgv_pkg coefficients and horner_step; stage enables come from the caller.
`timescale 1ns / 1ps

module tgv_sincos #(
	parameter int ABITS = tgv_pkg::ANGLE_BITS_DEF
) (
	input  logic               clk,
	input  logic [5:0]         en,
	input  logic [ABITS-1:0]   phase,
	output tgv_pkg::sincos_t   result
);

	logic [1:0]  quad;
	logic [29:0] x_in;
	logic [59:0] sq;

	assign quad = phase[ABITS-1:ABITS-2];
	assign x_in = {phase[ABITS-3:0], {(32 - ABITS){1'b0}}};
	assign sq   = 60'(x_in) * 60'(x_in);

	logic [1:0]  q_s1, q_s2, q_s3, q_s4, q_s5, q_s6;
	logic [29:0] x_s1, x_s2, x_s3, x_s4, x_s5;
	logic [29:0] y_s1, y_s2, y_s3, y_s4, y_s5;
	logic [30:0] sp_s2, sp_s3, sp_s4, sp_s5;
	logic [30:0] cp_s2, cp_s3, cp_s4, cp_s5;
	logic [30:0] s_s6, c_s6;

	logic [60:0] sprod, cprod;
	logic [30:0] st, ct;

	assign sprod = 61'(sp_s5) * 61'(x_s5);
	assign cprod = 61'(cp_s5) * 61'(y_s5);
	assign st    = sprod[60:30];
	assign ct    = cprod[60:30];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			q_s1 <= quad;
			x_s1 <= x_in;
			y_s1 <= sq[59:30];
		end
		if (en[1]) begin
			q_s2  <= q_s1;
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			sp_s2 <= tgv_pkg::horner_step(tgv_pkg::SIN_COEF[4], y_s1, tgv_pkg::SIN_COEF[3]);
			cp_s2 <= tgv_pkg::horner_step(tgv_pkg::COS_COEF[4], y_s1, tgv_pkg::COS_COEF[3]);
		end
		if (en[2]) begin
			q_s3  <= q_s2;
			x_s3  <= x_s2;
			y_s3  <= y_s2;
			sp_s3 <= tgv_pkg::horner_step(sp_s2, y_s2, tgv_pkg::SIN_COEF[2]);
			cp_s3 <= tgv_pkg::horner_step(cp_s2, y_s2, tgv_pkg::COS_COEF[2]);
		end
		if (en[3]) begin
			q_s4  <= q_s3;
			x_s4  <= x_s3;
			y_s4  <= y_s3;
			sp_s4 <= tgv_pkg::horner_step(sp_s3, y_s3, tgv_pkg::SIN_COEF[1]);
			cp_s4 <= tgv_pkg::horner_step(cp_s3, y_s3, tgv_pkg::COS_COEF[1]);
		end
		if (en[4]) begin
			q_s5  <= q_s4;
			x_s5  <= x_s4;
			y_s5  <= y_s4;
			sp_s5 <= tgv_pkg::horner_step(sp_s4, y_s4, tgv_pkg::SIN_COEF[0]);
			cp_s5 <= tgv_pkg::horner_step(cp_s4, y_s4, tgv_pkg::COS_COEF[0]);
		end
		if (en[5]) begin
			q_s6 <= q_s5;
			s_s6 <= (st > tgv_pkg::ONE_Q30) ? tgv_pkg::ONE_Q30 : st;
			c_s6 <= (ct >= tgv_pkg::ONE_Q30) ? 31'd0 : 31'(tgv_pkg::ONE_Q30 - ct);
		end
	end

	// quadrant fold
	always_comb begin
		case (q_s6)
			2'd0: begin
				result = '{sin_mag: s_s6, sin_neg: 1'b0, cos_mag: c_s6, cos_neg: 1'b0};
			end
			2'd1: begin
				result = '{sin_mag: c_s6, sin_neg: 1'b0, cos_mag: s_s6, cos_neg: 1'b1};
			end
			2'd2: begin
				result = '{sin_mag: s_s6, sin_neg: 1'b1, cos_mag: c_s6, cos_neg: 1'b1};
			end
			default: begin
				result = '{sin_mag: c_s6, sin_neg: 1'b1, cos_mag: s_s6, cos_neg: 1'b0};
			end
		endcase
	end

endmodule

FILE: sv/tgv_combine.sv
// tgv_combine: four-stage position math (radius products, rounding, saturation)
// and result assembly. Uses tgv_pkg types; stage enables come from the caller.
`timescale 1ns / 1ps

module tgv_combine (
	input  logic              clk,
	input  logic [3:0]        en,
	input  tgv_pkg::sincos_t  sc_u,
	input  tgv_pkg::sincos_t  sc_v,
	input  tgv_pkg::side_t    side_in,
	input  logic [14:0]       major_radius,
	input  logic [14:0]       minor_radius,
	output tgv_pkg::result_t  result
);

	function automatic logic [15:0] sat_mag(input logic [17:0] mag, input logic neg);
		logic [15:0] r;
		if (neg) begin
			r = (mag >= 18'd32768) ? 16'h8000 : 16'(-mag);
		end else begin
			r = (mag > 18'd32767) ? 16'h7FFF : mag[15:0];
		end
		return r;
	endfunction

	// stage 1: r*cos v and r*sin v
	logic [45:0] rc_prod, ry_prod;
	assign rc_prod = 46'(minor_radius) * 46'(sc_v.cos_mag) + 46'(1 << 14);
	assign ry_prod = 46'(minor_radius) * 46'(sc_v.sin_mag) + 46'(1 << 29);

	logic [30:0]      rc_s1;
	logic             rc_neg_s1;
	logic [15:0]      my_s1;
	logic             my_neg_s1;
	tgv_pkg::sincos_t u_s1, u_s2;
	tgv_pkg::side_t   side_s1, side_s2, side_s3;

	// stage 2: a = R + r*cos v, as sign and magnitude
	logic [32:0] base, a_sum;
	assign base  = {3'b000, major_radius, 15'd0};
	assign a_sum = rc_neg_s1 ? (base - 33'(rc_s1)) : (base + 33'(rc_s1));

	logic [31:0] a_mag_s2;
	logic        a_neg_s2;
	logic [15:0] py_s2, py_s3;

	// stage 3: a*cos u and a*sin u
	logic [63:0] x_prod, z_prod;
	assign x_prod = 64'(a_mag_s2) * 64'(u_s2.cos_mag) + 64'(64'd1 << 44);
	assign z_prod = 64'(a_mag_s2) * 64'(u_s2.sin_mag) + 64'(64'd1 << 44);

	logic [17:0] mx_s3, mz_s3;
	logic        nx_s3, nz_s3;

	tgv_pkg::result_t res_s4;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rc_s1     <= rc_prod[45:15];
			rc_neg_s1 <= sc_v.cos_neg;
			my_s1     <= ry_prod[45:30];
			my_neg_s1 <= sc_v.sin_neg;
			u_s1      <= sc_u;
			side_s1   <= side_in;
		end
		if (en[1]) begin
			a_neg_s2 <= a_sum[32];
			a_mag_s2 <= a_sum[32] ? 32'(-a_sum) : a_sum[31:0];
			py_s2    <= sat_mag(18'(my_s1), my_neg_s1);
			u_s2     <= u_s1;
			side_s2  <= side_s1;
		end
		if (en[2]) begin
			mx_s3   <= x_prod[62:45];
			mz_s3   <= z_prod[62:45];
			nx_s3   <= a_neg_s2 ^ u_s2.cos_neg;
			nz_s3   <= a_neg_s2 ^ u_s2.sin_neg;
			py_s3   <= py_s2;
			side_s3 <= side_s2;
		end
		if (en[3]) begin
			if (side_s3.err) begin
				res_s4 <= '{err: 1'b1, default: '0};
			end else begin
				res_s4.pos_x   <= sat_mag(mx_s3, nx_s3);
				res_s4.pos_y   <= py_s3;
				res_s4.pos_z   <= sat_mag(mz_s3, nz_s3);
				res_s4.tex_u   <= side_s3.tex_u;
				res_s4.tex_v   <= side_s3.tex_v;
				res_s4.idx_cur <= side_s3.idx_cur;
				res_s4.idx_nr  <= side_s3.idx_nr;
				res_s4.idx_dg  <= side_s3.idx_dg;
				res_s4.idx_nt  <= side_s3.idx_nt;
				res_s4.err     <= 1'b0;
			end
		end
	end

	assign result = res_s4;

endmodule

FILE: sv/torus_grid_vertex_generator_core.sv
// torus_grid_vertex_generator_core: top level, APB register file, stage control,
// index math. Instantiates tgv_div, tgv_sincos and tgv_combine; uses tgv_pkg.
`timescale 1ns / 1ps

// Streams one torus grid cell per clock unless the output stalls: each accepted
// (ring_index, tube_index) item yields one result with the vertex position
// (signed Q1.15, saturated), texture coordinates (unsigned Q0.16), the four
// triangle vertex indices and cell_error. Throughput is one item per cycle
// while out_ready is high. Items pass a capture stage, then the restoring
// divider that forms i/N two quotient bits per stage, followed by six
// sine/cosine stages and four position stages. Each stage has its own valid
// bit and the ready chain lets bubbles collapse, so a stalled output only
// holds back stages that are full. Registers (APB, byte address 4*i):
// ring_count, tube_count, major_radius, minor_radius; write them only
// while no item is in flight.
module torus_grid_vertex_generator_core #(
	parameter int ANGLE_BITS = tgv_pkg::ANGLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// cell input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ring_index,
	input  logic [7:0]  tube_index,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic signed [15:0] pos_z,
	output logic [15:0] tex_u,
	output logic [15:0] tex_v,
	output logic [15:0] index_current,
	output logic [15:0] index_next_ring,
	output logic [15:0] index_diagonal,
	output logic [15:0] index_next_tube,
	output logic        cell_error
);

	localparam int QBITS = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
	localparam int DS    = (QBITS + 1) / 2;   // divider stages
	localparam int SC_LO = DS + 2;            // first sin/cos stage
	localparam int SC_HI = DS + 7;            // last sin/cos stage
	localparam int L     = DS + 11;           // total stages

	// ---------------- configuration registers ----------------
	logic [8:0]  ring_count_q, tube_count_q;
	logic [14:0] major_radius_q, minor_radius_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q   <= tgv_pkg::RING_RESET;
			tube_count_q   <= tgv_pkg::TUBE_RESET;
			major_radius_q <= tgv_pkg::MAJOR_RESET;
			minor_radius_q <= tgv_pkg::MINOR_RESET;
		end else if (cfg_wr) begin
			unique case (tgv_pkg::reg_addr_t'(paddr[3:2]))
				tgv_pkg::REG_RING:  ring_count_q   <= pwdata[8:0];
				tgv_pkg::REG_TUBE:  tube_count_q   <= pwdata[8:0];
				tgv_pkg::REG_MAJOR: major_radius_q <= pwdata[14:0];
				tgv_pkg::REG_MINOR: minor_radius_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (tgv_pkg::reg_addr_t'(paddr[3:2]))
			tgv_pkg::REG_RING:  prdata = 32'(ring_count_q);
			tgv_pkg::REG_TUBE:  prdata = 32'(tube_count_q);
			tgv_pkg::REG_MAJOR: prdata = 32'(major_radius_q);
			tgv_pkg::REG_MINOR: prdata = 32'(minor_radius_q);
			default:            prdata = '0;
		endcase
	end

	// clamp counts into [min, MAX_SIDES]
	logic [8:0] nr_c, nt_c;
	assign nr_c = (ring_count_q < 9'(tgv_pkg::RING_MIN)) ? 9'(tgv_pkg::RING_MIN) :
		(ring_count_q > 9'(tgv_pkg::MAX_SIDES)) ? 9'(tgv_pkg::MAX_SIDES) : ring_count_q;
	assign nt_c = (tube_count_q < 9'(tgv_pkg::TUBE_MIN)) ? 9'(tgv_pkg::TUBE_MIN) :
		(tube_count_q > 9'(tgv_pkg::MAX_SIDES)) ? 9'(tgv_pkg::MAX_SIDES) : tube_count_q;

	// ---------------- stage control ----------------
	// a stage loads when it is empty or the one after it moves
	logic [L:1]   v_s;
	logic [L+1:1] en;

	always_comb begin
		en[L+1] = out_ready;
		for (int k = L; k >= 1; k--) begin
			en[k] = !v_s[k] | en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[1]) begin
				v_s[1] <= in_valid;
			end
			for (int k = 2; k <= L; k++) begin
				if (en[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
		end
	end

	assign in_ready  = en[1];
	assign out_valid = v_s[L];

	// ---------------- stage 1: capture ----------------
	logic [7:0] i_s1, j_s1;
	logic [8:0] nr_s1, nt_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			i_s1  <= ring_index;
			j_s1  <= tube_index;
			nr_s1 <= nr_c;
			nt_s1 <= nt_c;
		end
	end

	// wrapped neighbors and vertex indices
	logic [8:0]     ni, nj;
	logic [17:0]    row_i, row_ni;
	tgv_pkg::side_t side_c;

	assign ni     = (9'(i_s1) + 9'd1 == nr_s1) ? 9'd0 : 9'(i_s1) + 9'd1;
	assign nj     = (9'(j_s1) + 9'd1 == nt_s1) ? 9'd0 : 9'(j_s1) + 9'd1;
	assign row_i  = 18'(i_s1) * 18'(nt_s1);
	assign row_ni = 18'(ni) * 18'(nt_s1);

	always_comb begin
		side_c.err     = (9'(i_s1) >= nr_s1) | (9'(j_s1) >= nt_s1);
		side_c.tex_u   = '0;
		side_c.tex_v   = '0;
		side_c.idx_cur = 16'(row_i + 18'(j_s1));
		side_c.idx_nr  = 16'(row_ni + 18'(j_s1));
		side_c.idx_dg  = 16'(row_ni + 18'(nj));
		side_c.idx_nt  = 16'(row_i + 18'(nj));
	end

	// ---------------- stages 2..DS+1: dividers ----------------
	logic [QBITS-1:0] quo_u, quo_v;

	tgv_div #(.QBITS(QBITS)) u_div_u (
		.clk      (clk),
		.en       (en[DS+1:2]),
		.dividend (i_s1),
		.divisor  (nr_s1),
		.quotient (quo_u)
	);

	tgv_div #(.QBITS(QBITS)) u_div_v (
		.clk      (clk),
		.en       (en[DS+1:2]),
		.dividend (j_s1),
		.divisor  (nt_s1),
		.quotient (quo_v)
	);

	// side data rides beside the dividers and sin/cos stages; tex joins at SC_LO
	tgv_pkg::side_t side_s [2:SC_HI];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			side_s[2] <= side_c;
		end
		for (int k = 3; k <= SC_HI; k++) begin
			if (en[k]) begin
				if (k == SC_LO) begin
					side_s[k] <= '{err: side_s[k-1].err,
						tex_u: quo_u[QBITS-1 -: 16], tex_v: quo_v[QBITS-1 -: 16],
						idx_cur: side_s[k-1].idx_cur, idx_nr: side_s[k-1].idx_nr,
						idx_dg: side_s[k-1].idx_dg, idx_nt: side_s[k-1].idx_nt};
				end else begin
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	// ---------------- stages DS+2..DS+7: sine / cosine ----------------
	tgv_pkg::sincos_t sc_u, sc_v;

	tgv_sincos #(.ABITS(ANGLE_BITS)) u_sc_u (
		.clk    (clk),
		.en     (en[SC_HI:SC_LO]),
		.phase  (quo_u[QBITS-1 -: ANGLE_BITS]),
		.result (sc_u)
	);

	tgv_sincos #(.ABITS(ANGLE_BITS)) u_sc_v (
		.clk    (clk),
		.en     (en[SC_HI:SC_LO]),
		.phase  (quo_v[QBITS-1 -: ANGLE_BITS]),
		.result (sc_v)
	);

	// ---------------- stages DS+8..DS+11: position and output ----------------
	tgv_pkg::result_t res;

	tgv_combine u_combine (
		.clk          (clk),
		.en           (en[L:SC_HI+1]),
		.sc_u         (sc_u),
		.sc_v         (sc_v),
		.side_in      (side_s[SC_HI]),
		.major_radius (major_radius_q),
		.minor_radius (minor_radius_q),
		.result       (res)
	);

	assign pos_x           = res.pos_x;
	assign pos_y           = res.pos_y;
	assign pos_z           = res.pos_z;
	assign tex_u           = res.tex_u;
	assign tex_v           = res.tex_v;
	assign index_current   = res.idx_cur;
	assign index_next_ring = res.idx_nr;
	assign index_diagonal  = res.idx_dg;
	assign index_next_tube = res.idx_nt;
	assign cell_error      = res.err;

	// ---------------- assertions ----------------
	// an empty output stage lets the whole chain move
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low with empty output stage");

	// an error result carries zero position, tex_u, current and diagonal indices
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cell_error |-> pos_x == 16'd0 && pos_y == 16'd0 && pos_z == 16'd0 &&
			tex_u == 16'd0 && index_current == 16'd0 && index_diagonal == 16'd0)
		else $error("error result with nonzero fields");

	// the tube step is the same on both rows
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cell_error |->
			16'(index_diagonal - index_next_ring) == 16'(index_next_tube - index_current))
		else $error("inconsistent vertex indices");

endmodule
